[hdl/ccc_pkg.sv]
// Shared types, sizes, opcodes and helper functions for the concept closure unit.
// No dependencies; every other file of the block refers to this package by scope.
package ccc_pkg;

   // Context sizes.
   localparam int MAX_OBJECTS    = 64;
   localparam int MAX_ATTRIBUTES = 64;

   // Fixed field widths of the item interfaces.
   localparam int ROW_W     = 64;
   localparam int OPCODE_W  = 2;
   localparam int INDEX_W   = 6;
   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 1;

   // Width of a row address into the context store.
   localparam int OBJ_IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

   // Item opcodes.
   localparam logic [OPCODE_W-1:0] OP_WRITE   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FULL    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PARTIAL = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_OBJECTS    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ATTRIBUTES = 1'd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 accept;
      logic                 read;
      logic [OBJ_IDX_W-1:0] addr;
      logic                 finish;
   } ccc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_closure;
      logic out_free;
   } ccc_status_type;

   // Mask of the lowest n bits, with n saturated at cap.
   function automatic logic [ROW_W-1:0] low_mask(input logic [CSR_W-1:0] n, input int cap);
      logic [CSR_W-1:0] k;
      begin
         k = (int'(n) > cap) ? CSR_W'(cap) : n;
         if (k >= CSR_W'(ROW_W)) begin
            low_mask = '1;
         end else begin
            low_mask = (ROW_W'(1) << k) - ROW_W'(1);
         end
      end
   endfunction

endpackage

[hdl/ccc_req_if.sv]
// Request channel of the concept closure unit: valid, ready and one input item.
// Depends on ccc_pkg for field widths.
interface ccc_req_if;
   logic                         valid;
   logic                         ready;
   logic [ccc_pkg::OPCODE_W-1:0] opcode;
   logic [ccc_pkg::INDEX_W-1:0]  row_index;
   logic [ccc_pkg::ROW_W-1:0]    row_bits;
   logic [ccc_pkg::ROW_W-1:0]    extent_bits;
   logic [ccc_pkg::ROW_W-1:0]    intent_bits;
   logic [ccc_pkg::INDEX_W-1:0]  attribute;

   modport source (output valid, opcode, row_index, row_bits, extent_bits, intent_bits,
                   attribute, input ready);
   modport sink (input valid, opcode, row_index, row_bits, extent_bits, intent_bits,
                 attribute, output ready);
endinterface

// Response channel of the concept closure unit: valid, ready and one result item.
interface ccc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ccc_pkg::ROW_W-1:0] new_extent;
   logic [ccc_pkg::ROW_W-1:0] new_intent;
   logic                      canonical;
   logic                      extent_unchanged;

   modport source (output valid, new_extent, new_intent, canonical, extent_unchanged,
                   input ready);
   modport sink (input valid, new_extent, new_intent, canonical, extent_unchanged,
                 output ready);
endinterface

[hdl/concept_closure_canonicity_unit.sv]
// Close-by-one concept closure unit. A write item stores one object row of the
// context and returns an all-zero result. A closure item walks every object row
// of the context store, one row per cycle through the store's single read port,
// and its result enters the output register after the walk. One item is worked
// at a time; the next item is accepted as soon as the previous one has left for
// the output register, even while that result still waits to be taken. The
// result gives the kept extent, the new intent, the canonicity flag and the
// unchanged-extent flag. The user must write configuration only while the unit
// is idle; the unit itself does not enforce this.
// Depends on ccc_pkg, ccc_req_if, ccc_rsp_if, ccc_ctrl and ccc_dp.
module concept_closure_canonicity_unit (
   input  logic                           clock,
   input  logic                           reset,
   ccc_req_if.sink                        req,
   ccc_rsp_if.source                      rsp,
   input  logic                           csr_we,
   input  logic [ccc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ccc_pkg::CSR_W-1:0]      csr_wdata
);

   ccc_pkg::ccc_cmd_type    cmd;
   ccc_pkg::ccc_status_type status;
   logic                    ready;

   assign req.ready = ready;

   // Item sequencing.
   ccc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Context store and closure arithmetic.
   ccc_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_opcode           (req.opcode),
      .req_row_index        (req.row_index),
      .req_row_bits         (req.row_bits),
      .req_extent_bits      (req.extent_bits),
      .req_intent_bits      (req.intent_bits),
      .req_attribute        (req.attribute),
      .rsp_valid            (rsp.valid),
      .rsp_ready            (rsp.ready),
      .rsp_new_extent       (rsp.new_extent),
      .rsp_new_intent       (rsp.new_intent),
      .rsp_canonical        (rsp.canonical),
      .rsp_extent_unchanged (rsp.extent_unchanged)
   );

endmodule

[hdl/ccc_ctrl.sv]
// Controller of the concept closure unit: accepts items and sequences the row walk.
// Depends on ccc_pkg for the command and status types.
module ccc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ccc_pkg::ccc_status_type status,
   output ccc_pkg::ccc_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK   = 2'd1;
   localparam logic [1:0] S_TAIL   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   localparam logic [ccc_pkg::OBJ_IDX_W-1:0] LAST_ADDR =
      ccc_pkg::OBJ_IDX_W'(ccc_pkg::MAX_OBJECTS - 1);

   logic [1:0]                      state_ff, state_in;
   logic [ccc_pkg::OBJ_IDX_W-1:0]   addr_ff, addr_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.read   = 1'b0;
      cmd.addr   = addr_ff;
      cmd.finish = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               addr_in    = '0;
               state_in   = status.req_closure ? S_WALK : S_FINISH;
            end
         end
         S_WALK: begin
            // One context row is read per cycle, in object order.
            cmd.read = 1'b1;
            addr_in  = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            // The last row read is folded in this cycle.
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

endmodule

[hdl/ccc_dp.sv]
// Datapath of the concept closure unit: context store, closure accumulators,
// configuration registers and the result register. Depends on ccc_pkg.
module ccc_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  ccc_pkg::ccc_cmd_type             cmd,
   output ccc_pkg::ccc_status_type          status,
   input  logic                             csr_we,
   input  logic [ccc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ccc_pkg::CSR_W-1:0]        csr_wdata,
   input  logic [ccc_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [ccc_pkg::INDEX_W-1:0]      req_row_index,
   input  logic [ccc_pkg::ROW_W-1:0]        req_row_bits,
   input  logic [ccc_pkg::ROW_W-1:0]        req_extent_bits,
   input  logic [ccc_pkg::ROW_W-1:0]        req_intent_bits,
   input  logic [ccc_pkg::INDEX_W-1:0]      req_attribute,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ccc_pkg::ROW_W-1:0]        rsp_new_extent,
   output logic [ccc_pkg::ROW_W-1:0]        rsp_new_intent,
   output logic                             rsp_canonical,
   output logic                             rsp_extent_unchanged
);

   localparam int NO = ccc_pkg::MAX_OBJECTS;

   // Context store, one attribute row per object.
   logic [ccc_pkg::ROW_W-1:0] rows_mem [NO];
   logic [ccc_pkg::ROW_W-1:0] rd_data_ff;
   logic                      rd_valid_ff;

   // Configuration registers.
   logic [ccc_pkg::CSR_W-1:0] num_objects_ff;
   logic [ccc_pkg::CSR_W-1:0] num_attributes_ff;

   // Item registers and closure accumulators.
   logic [ccc_pkg::OPCODE_W-1:0] op_ff;
   logic [ccc_pkg::INDEX_W-1:0]  y_ff;
   logic [ccc_pkg::ROW_W-1:0]    amask_ff;
   logic [ccc_pkg::ROW_W-1:0]    below_ff;
   logic [ccc_pkg::ROW_W-1:0]    intent_ff;
   logic [NO-1:0]                ext_sh_ff;
   logic [NO-1:0]                newext_ff;
   logic [ccc_pkg::ROW_W-1:0]    acc_ff;
   logic                         same_ff;

   // Result register.
   logic                         rsp_valid_ff;
   logic [ccc_pkg::ROW_W-1:0]    new_extent_ff;
   logic [ccc_pkg::ROW_W-1:0]    new_intent_ff;
   logic                         canonical_ff;
   logic                         unchanged_ff;

   logic [ccc_pkg::ROW_W-1:0]    omask;
   logic [ccc_pkg::ROW_W-1:0]    row_masked;
   logic                         row_hit;
   logic                         is_closure;
   logic [ccc_pkg::ROW_W-1:0]    acc_final;

   // Status toward the controller.
   assign status.req_closure = (req_opcode == ccc_pkg::OP_FULL) ||
                               (req_opcode == ccc_pkg::OP_PARTIAL);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_objects_ff    <= ccc_pkg::CSR_W'(ccc_pkg::MAX_OBJECTS);
         num_attributes_ff <= ccc_pkg::CSR_W'(ccc_pkg::MAX_ATTRIBUTES);
      end else if (csr_we) begin
         unique case (csr_index)
            ccc_pkg::CSR_NUM_OBJECTS:    num_objects_ff    <= csr_wdata;
            ccc_pkg::CSR_NUM_ATTRIBUTES: num_attributes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Row writes go in at acceptance; walk reads have registered data.
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_opcode == ccc_pkg::OP_WRITE) &&
          (int'(req_row_index) < NO)) begin
         rows_mem[req_row_index[ccc_pkg::OBJ_IDX_W-1:0]] <= req_row_bits;
      end
      if (cmd.read) begin
         rd_data_ff <= rows_mem[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.read;
      end
   end

   // Row seen this cycle, limited to attributes in use.
   assign omask      = ccc_pkg::low_mask(num_objects_ff, ccc_pkg::MAX_OBJECTS);
   assign row_masked = rd_data_ff & amask_ff;
   assign row_hit    = row_masked[y_ff];

   // Item capture and the per-row fold. The extent shifts down one object per
   // row, and the kept objects shift into the new extent from the top.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_opcode;
         y_ff      <= req_attribute;
         amask_ff  <= ccc_pkg::low_mask(num_attributes_ff, ccc_pkg::MAX_ATTRIBUTES);
         acc_ff    <= ccc_pkg::low_mask(num_attributes_ff, ccc_pkg::MAX_ATTRIBUTES);
         below_ff  <= (ccc_pkg::ROW_W'(1) << req_attribute) - ccc_pkg::ROW_W'(1);
         intent_ff <= req_intent_bits;
         ext_sh_ff <= req_extent_bits[NO-1:0] & omask[NO-1:0];
         newext_ff <= '0;
         same_ff   <= 1'b1;
      end else if (rd_valid_ff) begin
         ext_sh_ff <= ext_sh_ff >> 1;
         if (NO > 1) begin
            newext_ff <= {ext_sh_ff[0] & row_hit, newext_ff[NO-1:1]};
         end else begin
            newext_ff <= NO'(ext_sh_ff[0] & row_hit);
         end
         if (ext_sh_ff[0]) begin
            if (row_hit) begin
               acc_ff <= acc_ff & row_masked;
            end else begin
               same_ff <= 1'b0;
            end
         end
      end
   end

   // Final intent and flags.
   assign is_closure = (op_ff == ccc_pkg::OP_FULL) || (op_ff == ccc_pkg::OP_PARTIAL);
   assign acc_final  = (op_ff == ccc_pkg::OP_PARTIAL) ? (acc_ff & below_ff) : acc_ff;

   // Result register; it holds until the item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (is_closure) begin
            new_extent_ff <= ccc_pkg::ROW_W'(newext_ff);
            new_intent_ff <= acc_final;
            canonical_ff  <= ((acc_final ^ intent_ff) & below_ff) == '0;
            unchanged_ff  <= same_ff;
         end else begin
            new_extent_ff <= '0;
            new_intent_ff <= '0;
            canonical_ff  <= 1'b0;
            unchanged_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_new_extent       = new_extent_ff;
   assign rsp_new_intent       = new_intent_ff;
   assign rsp_canonical        = canonical_ff;
   assign rsp_extent_unchanged = unchanged_ff;

endmodule
